@@ src/parrs_pkg.sv @@
// ----------------------------------------------------------------------------
// parrs_pkg: shared types and constants of the task scheduler core
// Item kind codes, the task table entry layout and sizing defaults.
// ----------------------------------------------------------------------------
package parrs_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int AGING_STEP    = 3;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic MODE_PRIO = 1'b0;
	localparam logic MODE_RR   = 1'b1;

	typedef struct packed {
		logic [7:0]         id;
		logic [7:0]         need;
		logic [7:0]         cpu;
		logic signed [15:0] prio;
	} task_t;

endpackage

@@ src/priority_aging_round_robin_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// priority_aging_round_robin_scheduler_core
// Task table and ready queue kept in two synchronous RAMs; a sequencer runs
// loads, ticks (retire / preempt / rotate, then one unit of service) and
// clears, and does a stable insertion sort of the queue in priority mode.
// ----------------------------------------------------------------------------
//  channel   signals                                        handshake
//  input     kind, task_id, need_time, start_priority       in_valid / in_ready
//  output    status, running_*, total_time, all_done       out_valid / out_ready
//  config    cfg_wdata (algorithm_mode)                     cfg_we, no wait
//
//  Steps: a load writes both RAMs, then sorts in priority mode; a tick retires,
//  rotates or preempts (the last with a sort and a new head), then serves one
//  unit if a task runs; clear, a refused load or a spare code go to the result.
//  The sort walks queue RAM then task RAM to pick up each entry and each compare
//  partner, shifting one slot per lower-priority partner; an in-order queue
//  needs one compare per entry, an unordered one up to n*n/2 compares.
//  One item at a time; a new item is taken while the last word still waits
//  at the output register, and a finished item holds in S_DONE until it frees.
//  Reset clears all control state at once.
// ----------------------------------------------------------------------------
module priority_aging_round_robin_scheduler_core #(
	parameter int MAX_TASKS = parrs_pkg::MAX_TASKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [7:0]         task_id,
	input  logic [7:0]         need_time,
	input  logic signed [7:0]  start_priority,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic               running_valid,
	output logic [7:0]         running_id,
	output logic [7:0]         running_need,
	output logic [7:0]         running_cpu,
	output logic signed [15:0] running_priority,
	output logic [15:0]        total_time,
	output logic               all_done,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef enum logic [16:0] {
		S_IDLE    = 17'h00001,
		S_LOAD    = 17'h00002,
		S_SORT_I  = 17'h00004,
		S_SORT_K  = 17'h00008,
		S_SORT_KP = 17'h00010,
		S_SORT_J  = 17'h00020,
		S_SORT_C  = 17'h00040,
		S_SORT_CP = 17'h00080,
		S_RUN_RD  = 17'h00100,
		S_RUN_CHK = 17'h00200,
		S_HEAD_Q  = 17'h00400,
		S_HEAD_T  = 17'h00800,
		S_FETCH   = 17'h01000,
		S_FETCH_D = 17'h02000,
		S_EXEC    = 17'h04000,
		S_EXEC_D  = 17'h08000,
		S_DONE    = 17'h10000
	} state_t;

	state_t st_q;

	// task table and ready queue RAMs
	parrs_pkg::task_t tmem [MAX_TASKS];
	logic [IW-1:0]    qmem [MAX_TASKS];

	parrs_pkg::task_t t_rdata_q, t_wdata;
	logic [IW-1:0]    t_raddr, t_waddr;
	logic             t_we;
	logic [IW-1:0]    q_rdata_q, q_raddr, q_waddr, q_wdata;
	logic             q_we;

	// control state
	logic             mode_q;
	logic [CW-1:0]    count_q, loaded_q;
	logic [IW-1:0]    head_q, run_slot_q;
	logic             present_q, sorted_q;
	logic [15:0]      tick_q;

	// item and sort working registers
	logic [7:0]         id_q, need_q;
	logic signed [7:0]  prio_q;
	logic [CW-1:0]      sort_i_q, sort_j_q;
	logic [IW-1:0]      key_q, cand_q;
	logic signed [15:0] key_prio_q;
	logic               sort_fetch_q;
	parrs_pkg::task_t   rt_q;

	// result held until the output register is free
	logic               res_status_q, res_ran_q;
	parrs_pkg::task_t   res_q;

	logic               out_valid_q, status_q, ran_q, done_q;
	parrs_pkg::task_t   out_q;
	logic [15:0]        time_q;

	logic [CW-1:0]      jm1;
	logic signed [16:0] aged;
	parrs_pkg::task_t   upd;
	logic [IW-1:0]      head_inc;

	// logical queue position to RAM address
	function automatic logic [IW-1:0] phys(input logic [CW-1:0] k);
		logic [CW:0] sum;
		begin
			sum = (CW+1)'(head_q) + (CW+1)'(k);
			if (sum >= (CW+1)'(MAX_TASKS))
				sum = sum - (CW+1)'(MAX_TASKS);
			phys = sum[IW-1:0];
		end
	endfunction

	assign jm1      = sort_j_q - 1'b1;
	assign head_inc = (head_q == IW'(MAX_TASKS - 1)) ? '0 : head_q + 1'b1;

	// one unit of service on the entry just read
	always_comb begin
		upd      = t_rdata_q;
		aged     = {t_rdata_q.prio[15], t_rdata_q.prio} - 17'(parrs_pkg::AGING_STEP);
		if (t_rdata_q.cpu != 8'hFF)
			upd.cpu = t_rdata_q.cpu + 8'd1;
		if (t_rdata_q.need != 8'd0)
			upd.need = t_rdata_q.need - 8'd1;
		if (mode_q == parrs_pkg::MODE_PRIO)
			upd.prio = (aged[16] != aged[15]) ? 16'sh8000 : aged[15:0];
	end

	// RAM addresses and writes
	always_comb begin
		q_raddr = head_q;
		t_raddr = run_slot_q;
		q_we    = 1'b0;
		q_waddr = phys(count_q);
		q_wdata = run_slot_q;
		t_we    = 1'b0;
		t_waddr = run_slot_q;
		t_wdata = upd;
		case (st_q)
			S_LOAD: begin
				t_we    = 1'b1;
				t_waddr = loaded_q[IW-1:0];
				t_wdata = '{id: id_q, need: need_q, cpu: 8'd0, prio: 16'(prio_q)};
				q_we    = 1'b1;
				q_wdata = loaded_q[IW-1:0];
			end
			S_SORT_I:  q_raddr = phys(sort_i_q);
			S_SORT_K:  t_raddr = q_rdata_q;
			S_SORT_J: begin
				q_raddr = phys(jm1);
				if (sort_j_q == '0) begin
					q_we    = 1'b1;
					q_waddr = phys(sort_j_q);
					q_wdata = key_q;
				end
			end
			S_SORT_C:  t_raddr = q_rdata_q;
			S_SORT_CP: begin
				q_we    = 1'b1;
				q_waddr = phys(sort_j_q);
				q_wdata = (t_rdata_q.prio < key_prio_q) ? cand_q : key_q;
			end
			S_RUN_CHK: q_we = (mode_q == parrs_pkg::MODE_RR) && (t_rdata_q.need != 8'd0);
			S_HEAD_Q:  t_raddr = q_rdata_q;
			S_HEAD_T:  q_we = rt_q.prio < t_rdata_q.prio;
			S_EXEC_D:  t_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (t_we)
			tmem[t_waddr] <= t_wdata;
		if (q_we)
			qmem[q_waddr] <= q_wdata;
		t_rdata_q <= tmem[t_raddr];
		q_rdata_q <= qmem[q_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= parrs_pkg::MODE_PRIO;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			count_q      <= '0;
			loaded_q     <= '0;
			head_q       <= '0;
			run_slot_q   <= '0;
			present_q    <= 1'b0;
			sorted_q     <= 1'b1;
			tick_q       <= '0;
			sort_fetch_q <= 1'b0;
			res_status_q <= 1'b0;
			res_ran_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// S_DONE reloads the output register itself
			if (out_valid_q && out_ready && st_q != S_DONE)
				out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						id_q         <= task_id;
						need_q       <= need_time;
						prio_q       <= start_priority;
						res_status_q <= 1'b0;
						res_ran_q    <= 1'b0;
						st_q         <= S_DONE;
						case (kind)
							parrs_pkg::KIND_LOAD: begin
								if (loaded_q >= CW'(MAX_TASKS))
									res_status_q <= 1'b1;
								else
									st_q <= S_LOAD;
							end
							parrs_pkg::KIND_TICK: begin
								if (tick_q != 16'hFFFF)
									tick_q <= tick_q + 16'd1;
								st_q <= present_q ? S_RUN_RD : S_FETCH;
							end
							parrs_pkg::KIND_CLEAR: begin
								count_q    <= '0;
								loaded_q   <= '0;
								head_q     <= '0;
								run_slot_q <= '0;
								present_q  <= 1'b0;
								sorted_q   <= 1'b1;
								tick_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				S_LOAD: begin
					count_q  <= count_q + 1'b1;
					loaded_q <= loaded_q + 1'b1;
					if (mode_q == parrs_pkg::MODE_PRIO) begin
						sort_i_q     <= sorted_q ? count_q : CW'(1);
						sort_fetch_q <= 1'b0;
						st_q         <= S_SORT_I;
					end else begin
						sorted_q <= 1'b0;
						st_q     <= S_DONE;
					end
				end
				S_SORT_I: begin
					sort_j_q <= sort_i_q;
					if (sort_i_q >= count_q) begin
						sorted_q <= 1'b1;
						st_q     <= sort_fetch_q ? S_FETCH : S_DONE;
					end else begin
						st_q <= S_SORT_K;
					end
				end
				S_SORT_K: begin
					key_q <= q_rdata_q;
					st_q  <= S_SORT_KP;
				end
				S_SORT_KP: begin
					key_prio_q <= t_rdata_q.prio;
					st_q       <= S_SORT_J;
				end
				S_SORT_J: begin
					if (sort_j_q == '0) begin
						sort_i_q <= sort_i_q + 1'b1;
						st_q     <= S_SORT_I;
					end else begin
						st_q <= S_SORT_C;
					end
				end
				S_SORT_C: begin
					cand_q <= q_rdata_q;
					st_q   <= S_SORT_CP;
				end
				S_SORT_CP: begin
					// stable: only a strictly lower priority moves back
					if (t_rdata_q.prio < key_prio_q) begin
						sort_j_q <= jm1;
						st_q     <= S_SORT_J;
					end else begin
						sort_i_q <= sort_i_q + 1'b1;
						st_q     <= S_SORT_I;
					end
				end
				S_RUN_RD: st_q <= S_RUN_CHK;
				S_RUN_CHK: begin
					rt_q <= t_rdata_q;
					if (mode_q == parrs_pkg::MODE_RR) begin
						if (t_rdata_q.need != 8'd0) begin
							count_q  <= count_q + 1'b1;
							sorted_q <= 1'b0;
						end
						st_q <= S_FETCH;
					end else if (t_rdata_q.need == 8'd0) begin
						st_q <= S_FETCH;
					end else if (count_q != '0) begin
						st_q <= S_HEAD_Q;
					end else begin
						st_q <= S_EXEC;
					end
				end
				S_HEAD_Q: st_q <= S_HEAD_T;
				S_HEAD_T: begin
					if (rt_q.prio < t_rdata_q.prio) begin
						// preempt: requeue running task, re-sort, take new head
						count_q      <= count_q + 1'b1;
						sort_i_q     <= sorted_q ? count_q : CW'(1);
						sort_fetch_q <= 1'b1;
						st_q         <= S_SORT_I;
					end else begin
						st_q <= S_EXEC;
					end
				end
				S_FETCH: begin
					if (count_q == '0) begin
						present_q <= 1'b0;
						st_q      <= S_DONE;
					end else begin
						st_q <= S_FETCH_D;
					end
				end
				S_FETCH_D: begin
					run_slot_q <= q_rdata_q;
					present_q  <= 1'b1;
					head_q     <= head_inc;
					count_q    <= count_q - 1'b1;
					st_q       <= S_EXEC;
				end
				S_EXEC: st_q <= S_EXEC_D;
				S_EXEC_D: begin
					res_ran_q <= 1'b1;
					res_q     <= upd;
					// last task done: nothing stays running
					if (count_q == '0 && upd.need == 8'd0)
						present_q <= 1'b0;
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						ran_q       <= res_ran_q;
						out_q       <= res_ran_q ? res_q : '0;
						time_q      <= tick_q;
						done_q      <= (count_q == '0) && !present_q;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready         = (st_q == S_IDLE);
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign running_valid    = ran_q;
	assign running_id       = out_q.id;
	assign running_need     = out_q.need;
	assign running_cpu      = out_q.cpu;
	assign running_priority = out_q.prio;
	assign total_time       = time_q;
	assign all_done         = done_q;

	// between items, queued plus running tasks never exceed the loaded ones
	a_task_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_IDLE |->
		((CW+1)'(count_q) + (CW+1)'(present_q)) <= (CW+1)'(loaded_q))
		else $error("queue and running task exceed table fill");

	a_table_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CW'(MAX_TASKS))
		else $error("table fill beyond capacity");

	a_fetch_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_FETCH_D |-> count_q != '0)
		else $error("fetch from empty queue");

	a_sort_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_SORT_J |-> sort_j_q < count_q)
		else $error("sort index outside queue");

endmodule
